// ----- rtl/core/mr_pkg.sv -----
// Shared types, constants and the witness table for the Miller-Rabin prime tester.
// Used by mr_mulmod, mr_datapath, mr_ctrl and miller_rabin_prime_test_top.
package mr_pkg;

  localparam int NUM_BITS    = 63;
  localparam int WIT_W       = 32;
  localparam int Y_W         = (NUM_BITS > WIT_W) ? NUM_BITS : WIT_W;
  localparam int CNT_W       = $clog2(NUM_BITS + 1);
  localparam int YCNT_W      = $clog2(Y_W);
  localparam int IN_TDATA_W  = ((NUM_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;
  localparam int WIT_COUNT   = 7;
  localparam int WIT_IDX_W   = $clog2(WIT_COUNT);

  typedef enum logic [1:0] {
    MS_RED,
    MS_ACC,
    MS_SQB,
    MS_SQV
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     shift_u;
    logic     start_exp;
    logic     shift_e;
    logic     clr_j;
    logic     inc_j;
    logic     mul_start;
    mul_sel_e mul_sel;
    logic [WIT_IDX_W-1:0] wit_idx;
  } cmd_t;

  typedef struct packed {
    logic n_small;
    logic n_even;
    logic n_two;
    logic u_even;
    logic e_zero;
    logic e_lsb;
    logic v_one;
    logic v_nm1;
    logic v_zero;
    logic j_eq_t;
    logic mul_done;
  } sts_t;

  function automatic logic [WIT_W-1:0] witness(input logic [WIT_IDX_W-1:0] idx);
    logic [WIT_W-1:0] w;
    case (idx)
      3'd0:    w = 32'd2;
      3'd1:    w = 32'd325;
      3'd2:    w = 32'd9375;
      3'd3:    w = 32'd28178;
      3'd4:    w = 32'd450775;
      3'd5:    w = 32'd9780504;
      3'd6:    w = 32'd1795265022;
      default: w = 32'd2;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/mr_mulmod.sv -----
// Bit-serial modular multiplier: (x * y) mod m, one bit of y per cycle, MSB first.
// Depends on mr_pkg for widths.
module mr_mulmod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [mr_pkg::NUM_BITS-1:0] x_i,
  input  logic [mr_pkg::Y_W-1:0]      y_i,
  input  logic [mr_pkg::NUM_BITS-1:0] m_i,
  output logic                         done_o,
  output logic [mr_pkg::NUM_BITS-1:0] res_o
);

  localparam int W = mr_pkg::NUM_BITS;

  logic [W-1:0]                acc_q, acc_d;
  logic [W-1:0]                x_q, m_q;
  logic [mr_pkg::Y_W-1:0]      y_q;
  logic [mr_pkg::YCNT_W-1:0]   cnt_q;
  logic                        busy_q, done_q;
  logic [W:0]                  dbl, s1, add, s2;

  always_comb begin
    dbl = {acc_q, 1'b0};
    s1  = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    add = s1 + {1'b0, x_q};
    if (!y_q[mr_pkg::Y_W-1]) begin
      add = s1;
    end
    s2    = (add >= {1'b0, m_q}) ? add - {1'b0, m_q} : add;
    acc_d = s2[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
      m_q   <= m_i;
      cnt_q <= mr_pkg::YCNT_W'(mr_pkg::Y_W - 1);
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[mr_pkg::Y_W-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// ----- rtl/core/mr_datapath.sv -----
// Datapath of the prime tester: operand registers, counters and the shared multiplier.
// Depends on mr_pkg and mr_mulmod.
module mr_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mr_pkg::NUM_BITS-1:0] number_i,
  input  mr_pkg::cmd_t                 cmd_i,
  output mr_pkg::sts_t                 sts_o
);

  localparam int W = mr_pkg::NUM_BITS;

  logic [W-1:0]              n_q, u_q, e_q, acc_q, base_q, res;
  logic [mr_pkg::CNT_W-1:0]  t_q, j_q;
  mr_pkg::mul_sel_e          dst_q;
  logic [W-1:0]              mx, nm1;
  logic [mr_pkg::Y_W-1:0]    my;
  logic                      done;

  always_comb begin
    case (cmd_i.mul_sel)
      mr_pkg::MS_RED: begin
        mx = W'(1);
        my = mr_pkg::Y_W'(mr_pkg::witness(cmd_i.wit_idx));
      end
      mr_pkg::MS_ACC: begin
        mx = acc_q;
        my = mr_pkg::Y_W'(base_q);
      end
      mr_pkg::MS_SQB: begin
        mx = base_q;
        my = mr_pkg::Y_W'(base_q);
      end
      default: begin
        mx = acc_q;
        my = mr_pkg::Y_W'(acc_q);
      end
    endcase
  end

  mr_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mx),
    .y_i     (my),
    .m_i     (n_q),
    .done_o  (done),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= number_i;
      u_q <= number_i - W'(1);
      t_q <= '0;
    end
    if (cmd_i.shift_u) begin
      u_q <= u_q >> 1;
      t_q <= t_q + 1'b1;
    end
    if (cmd_i.start_exp) begin
      e_q   <= u_q;
      acc_q <= W'(1);
    end
    if (cmd_i.shift_e) begin
      e_q <= e_q >> 1;
    end
    if (cmd_i.clr_j) begin
      j_q <= mr_pkg::CNT_W'(1);
    end else if (cmd_i.inc_j) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.mul_start) begin
      dst_q <= cmd_i.mul_sel;
    end
    if (done) begin
      if (dst_q == mr_pkg::MS_RED || dst_q == mr_pkg::MS_SQB) begin
        base_q <= res;
      end else begin
        acc_q <= res;
      end
    end
  end

  assign nm1 = n_q - W'(1);

  always_comb begin
    sts_o.n_small  = n_q < W'(3);
    sts_o.n_even   = !n_q[0];
    sts_o.n_two    = n_q == W'(2);
    sts_o.u_even   = !u_q[0];
    sts_o.e_zero   = e_q == '0;
    sts_o.e_lsb    = e_q[0];
    sts_o.v_one    = acc_q == W'(1);
    sts_o.v_nm1    = acc_q == nm1;
    sts_o.v_zero   = acc_q == '0;
    sts_o.j_eq_t   = j_q == t_q;
    sts_o.mul_done = done;
  end

endmodule

// ----- rtl/core/mr_ctrl.sv -----
// Controller state machine of the prime tester: sequences decomposition,
// exponentiation and squaring per witness, and holds the result register.
// Depends on mr_pkg.
module mr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          flag_o,
  input  mr_pkg::sts_t  sts_i,
  output mr_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECOMP,
    ST_RED,
    ST_RED_W,
    ST_POW,
    ST_POW_A,
    ST_POW_S,
    ST_POW_B,
    ST_CHK,
    ST_SQ,
    ST_SQ_W,
    ST_SQ_T,
    ST_NEXT,
    ST_FIN
  } state_e;

  state_e                      state_q, state_d;
  logic [mr_pkg::WIT_IDX_W-1:0] widx_q, widx_d;
  logic                        res_q, res_d;
  logic                        oval_q, oval_d;
  logic                        flag_q, flag_d;
  logic                        in_acc;

  assign in_ready_o = state_q == ST_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    widx_d  = widx_q;
    res_d   = res_q;
    oval_d  = oval_q;
    flag_d  = flag_q;
    cmd_o   = '0;
    cmd_o.wit_idx = widx_q;
    cmd_o.mul_sel = mr_pkg::MS_RED;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECOMP;
        end
      end
      ST_DECOMP: begin
        if (sts_i.n_small || sts_i.n_even) begin
          res_d   = sts_i.n_two;
          state_d = ST_FIN;
        end else if (sts_i.u_even) begin
          cmd_o.shift_u = 1'b1;
        end else begin
          widx_d  = '0;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = mr_pkg::MS_RED;
        state_d         = ST_RED_W;
      end
      ST_RED_W: begin
        if (sts_i.mul_done) begin
          cmd_o.start_exp = 1'b1;
          state_d         = ST_POW;
        end
      end
      ST_POW: begin
        if (sts_i.e_zero) begin
          state_d = ST_CHK;
        end else if (sts_i.e_lsb) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = mr_pkg::MS_ACC;
          state_d         = ST_POW_A;
        end else begin
          state_d = ST_POW_S;
        end
      end
      ST_POW_A: begin
        if (sts_i.mul_done) begin
          state_d = ST_POW_S;
        end
      end
      ST_POW_S: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = mr_pkg::MS_SQB;
        state_d         = ST_POW_B;
      end
      ST_POW_B: begin
        if (sts_i.mul_done) begin
          cmd_o.shift_e = 1'b1;
          state_d       = ST_POW;
        end
      end
      ST_CHK: begin
        if (sts_i.v_one || sts_i.v_nm1 || sts_i.v_zero) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.clr_j = 1'b1;
          state_d     = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = mr_pkg::MS_SQV;
        state_d         = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (sts_i.mul_done) begin
          state_d = ST_SQ_T;
        end
      end
      ST_SQ_T: begin
        if (sts_i.v_nm1 && !sts_i.j_eq_t) begin
          state_d = ST_NEXT;
        end else if (sts_i.v_one || sts_i.j_eq_t) begin
          res_d   = 1'b0;
          state_d = ST_FIN;
        end else begin
          cmd_o.inc_j = 1'b1;
          state_d     = ST_SQ;
        end
      end
      ST_NEXT: begin
        if (widx_q == mr_pkg::WIT_IDX_W'(mr_pkg::WIT_COUNT - 1)) begin
          res_d   = 1'b1;
          state_d = ST_FIN;
        end else begin
          widx_d  = widx_q + 1'b1;
          state_d = ST_RED;
        end
      end
      ST_FIN: begin
        if (!oval_q || out_ready_i) begin
          oval_d  = 1'b1;
          flag_d  = res_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      widx_q  <= '0;
      res_q   <= 1'b0;
      oval_q  <= 1'b0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
      res_q   <= res_d;
      oval_q  <= oval_d;
      flag_q  <= flag_d;
    end
  end

  assign out_valid_o = oval_q;
  assign flag_o      = flag_q;

endmodule

// ----- rtl/core/miller_rabin_prime_test_top.sv -----
// For numbers below 3 or even, the result is decided in ST_DECOMP and passes through ST_FIN into the output register.
// Otherwise each witness takes a reduction, a product per set bit of u, a squaring per bit of u and the
// squarings for n-1 = u * 2^t, for up to seven witnesses, each product on the bit-serial multiplier.
// Throughput: one number at a time; the next is taken once the result enters the output register.
// Reset: asynchronous, active low; clears the controller and the output valid.
// Depends on mr_pkg, mr_ctrl, mr_datapath and mr_mulmod.
module miller_rabin_prime_test_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [62:0] number
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mr_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [0] prime_flag
);

  mr_pkg::cmd_t cmd;
  mr_pkg::sts_t sts;
  logic         flag;

  mr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .flag_o      (flag),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mr_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (s_axis_tdata[mr_pkg::NUM_BITS-1:0]),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

  assign m_axis_tdata = mr_pkg::OUT_TDATA_W'(flag);

endmodule

// ----- rtl/core/mr_checker.sv -----
// Port-level checker for the prime tester, bound to the top level.
// Depends on miller_rabin_prime_test_top and mr_pkg.
module mr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input taken while a number is in progress.");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("Result appeared in the cycle after the input transfer.");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[mr_pkg::OUT_TDATA_W-1:1] == '0)
    else $error("Padding bits of the result are not zero.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result changed.");

endmodule

bind miller_rabin_prime_test_top mr_checker u_mr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
